[sv/sorted_priority_queue_macros.svh]
// Assertion helpers used by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that implies another in the cycle after.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/spq_pkg.sv]
`default_nettype none
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int OUT_CNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [VAL_W-1:0] EMPTY_FRONT = -32'sd1;

  // Operation broadcast to every cell at once.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] key;
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    take;
    logic signed [VAL_W-1:0] value;
  } cell_link_t;

endpackage
`default_nettype wire

[sv/spq_in_if.sv]
`default_nettype none
interface spq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic signed [spq_pkg::VAL_W-1:0]      value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

[sv/spq_out_if.sv]
`default_nettype none
interface spq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [spq_pkg::ST_W-1:0]              status;
  logic signed [spq_pkg::VAL_W-1:0]      removed_value;
  logic signed [spq_pkg::VAL_W-1:0]      front_value;
  logic [spq_pkg::OUT_CNT_W-1:0]         entry_count;

  modport source (output valid, output status, output removed_value,
                  output front_value, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input front_value, input entry_count, output ready);
endinterface
`default_nettype wire

[sv/spq_cell.sv]
`default_nettype none
module spq_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire spq_pkg::cell_link_t left,
  input  wire spq_pkg::cell_link_t right,
  output spq_pkg::cell_link_t      link
);

  logic                            valid;
  logic signed [spq_pkg::VAL_W-1:0] value;
  logic                            take;

  // Entries are sorted, so take is false up to the insertion point and true from it on.
  assign take = !valid || ($signed(value) < $signed(ctrl.key));

  assign link.valid = valid;
  assign link.take  = take;
  assign link.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.rem) begin
      valid <= right.valid;
    end else if (ctrl.ins && take) begin
      valid <= left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rem) begin
      value <= right.value;
    end else if (ctrl.ins && take) begin
      value <= left.take ? left.value : ctrl.key;
    end
  end

endmodule
`default_nettype wire

[sv/sorted_priority_queue.sv]
// Sorted priority queue, largest entry at the front.
//
// cmd carries one command per transaction: insert value, or remove the
// front entry. res returns exactly one result per command: status, the
// removed entry, the new front value (-1 when empty) and the entry count.
// Equal keys leave in arrival order.
//
// The entries live in a row of cells. Every cell compares its entry with
// the new key at once and shifts toward the back on insert or toward the
// front on remove, so each command completes in the cycle it is accepted.
// The result appears in the cycle after acceptance, from an output register,
// and a new command is taken every cycle as long as res is not stalled.
// While res is stalled with a result pending, cmd.ready is low.
//
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue (
  input  wire logic clk,
  input  wire logic rst,
  spq_in_if.sink    cmd,
  spq_out_if.source res
);

  localparam int N = spq_pkg::CAPACITY;

  spq_pkg::cell_ctrl_t          ctrl;
  spq_pkg::cell_link_t          links [N];
  logic [N-1:0]                 valid_vec;
  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::CNT_W-1:0]    count_next;
  logic                         accept;
  logic                         full;
  logic                         empty;

  logic                              res_valid;
  logic [spq_pkg::ST_W-1:0]          res_status;
  logic signed [spq_pkg::VAL_W-1:0]  res_removed;
  logic signed [spq_pkg::VAL_W-1:0]  res_front;
  logic [spq_pkg::OUT_CNT_W-1:0]     res_count;

  logic [spq_pkg::ST_W-1:0]          status_next;
  logic signed [spq_pkg::VAL_W-1:0]  removed_next;
  logic signed [spq_pkg::VAL_W-1:0]  front_next;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == spq_pkg::CNT_W'(N));
  assign empty     = (count == '0);

  assign ctrl.ins = accept && (cmd.command == spq_pkg::CMD_INSERT) && !full;
  assign ctrl.rem = accept && (cmd.command == spq_pkg::CMD_REMOVE) && !empty;
  assign ctrl.key = cmd.value;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      spq_pkg::cell_link_t left_l;
      spq_pkg::cell_link_t right_l;
      if (g == 0) begin : g_head
        assign left_l = '{valid: 1'b1, take: 1'b0, value: '0};
      end else begin : g_mid
        assign left_l = links[g-1];
      end
      if (g == N - 1) begin : g_tail
        assign right_l = '{valid: 1'b0, take: 1'b1, value: '0};
      end else begin : g_body
        assign right_l = links[g+1];
      end
      spq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .left  (left_l),
        .right (right_l),
        .link  (links[g])
      );
      assign valid_vec[g] = links[g].valid;
    end
  endgenerate

  always_comb begin
    count_next   = count;
    status_next  = spq_pkg::ST_OK;
    removed_next = '0;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next   = count - 1'b1;
      removed_next = links[0].value;
    end else if (cmd.command == spq_pkg::CMD_INSERT) begin
      status_next = spq_pkg::ST_FULL;
    end else begin
      status_next = spq_pkg::ST_EMPTY;
    end

    if (count_next == '0) begin
      front_next = spq_pkg::EMPTY_FRONT;
    end else if (ctrl.ins) begin
      front_next = links[0].take ? cmd.value : links[0].value;
    end else if (ctrl.rem) begin
      front_next = links[1].value;
    end else begin
      front_next = links[0].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status  <= status_next;
      res_removed <= removed_next;
      res_front   <= front_next;
      res_count   <= spq_pkg::OUT_CNT_W'(32'(count_next));
    end
  end

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.removed_value = res_removed;
  assign res.front_value   = res_front;
  assign res.entry_count   = res_count;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count <= spq_pkg::CNT_W'(N), "entry count above capacity")
  `SPQ_ASSERT_ALWAYS(a_valid_count, $countones(valid_vec) == 32'(count), "cell valid bits disagree with count")
  `SPQ_ASSERT_NEXT(a_full_drop, accept && (cmd.command == spq_pkg::CMD_INSERT) && full, res_valid && (res_status == spq_pkg::ST_FULL) && (count == $past(count)), "insert on full queue not dropped")
  `SPQ_ASSERT_NEXT(a_empty_front, accept && (count_next == '0), res_front == spq_pkg::EMPTY_FRONT, "empty queue front is not -1")

endmodule
`default_nettype wire
